// ===== design/vnfis_pkg.sv =====
// ----------------------------------------------------------------------------
// vnfis_pkg
// Shared constants and binary32 arithmetic for the vector normalize pipeline.
// ----------------------------------------------------------------------------
package vnfis_pkg;

  localparam logic [31:0] CANON_NAN   = 32'h7fc0_0000;
  localparam logic [31:0] GUESS_MAGIC = 32'h5f37_59df;
  localparam logic [31:0] FP_HALF     = 32'h3f00_0000;
  localparam logic [31:0] FP_THREE_HALVES = 32'h3fc0_0000;
  localparam int unsigned NUM_STAGES  = 8;

  function automatic logic is_nan(input logic [31:0] a);
    is_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
  endfunction

  function automatic logic [31:0] canon(input logic [31:0] a);
    canon = is_nan(a) ? CANON_NAN : a;
  endfunction

  // first guess from the bits of d (arithmetic shift, wrapping subtract)
  function automatic logic [31:0] first_guess(input logic [31:0] d);
    logic [31:0] b;
    logic [31:0] sh;
    b  = canon(d);
    sh = {b[31], b[31:1]};
    first_guess = GUESS_MAGIC - sh;
  endfunction

  // binary32 multiply, round to nearest even, subnormals kept
  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic               sr;
    logic               a_inf, b_inf, a_zero, b_zero;
    logic [7:0]         ea, eb;
    logic [23:0]        ma, mb;
    logic [47:0]        p;
    logic [5:0]         lead;
    logic signed [10:0] er;
    logic signed [10:0] rs;
    logic [10:0]        rsu;
    logic [47:0]        shv;
    logic [47:0]        mask;
    logic [23:0]        sig;
    logic               rnd, stk;
    logic [7:0]         ef;
    logic [30:0]        pk;
    sr     = a[31] ^ b[31];
    a_inf  = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma     = {a[30:23] != 8'd0, a[22:0]};
    mb     = {b[30:23] != 8'd0, b[22:0]};
    p      = ma * mb;
    lead   = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (p[i]) lead = i[5:0];
    end
    er  = $signed({3'b0, ea}) + $signed({3'b0, eb}) + $signed({5'b0, lead}) - 11'sd173;
    rs  = $signed({5'b0, lead}) - 11'sd23 + ((er < 11'sd1) ? (11'sd1 - er) : 11'sd0);
    sig = 24'd0;
    rnd = 1'b0;
    stk = 1'b0;
    if (rs <= 11'sd0) begin
      rsu = 11'd0 - rs;
      shv = p << rsu;
      sig = shv[23:0];
    end else if (rs > 11'sd48) begin
      stk = 1'b1;
    end else begin
      rsu  = rs;
      shv  = p >> rsu;
      sig  = shv[23:0];
      shv  = p >> (rsu - 11'd1);
      rnd  = shv[0];
      mask = (48'd1 << (rsu - 11'd1)) - 48'd1;
      stk  = |(p & mask);
    end
    ef = (er >= 11'sd1) ? er[7:0] : 8'd0;
    pk = {ef, sig[22:0]} + {30'd0, rnd & (stk | sig[0])};
    if (is_nan(a) || is_nan(b)) begin
      fp_mul = CANON_NAN;
    end else if (a_inf || b_inf) begin
      fp_mul = (a_zero || b_zero) ? CANON_NAN : {sr, 8'hff, 23'd0};
    end else if (a_zero || b_zero) begin
      fp_mul = {sr, 31'd0};
    end else if (er >= 11'sd255) begin
      fp_mul = {sr, 8'hff, 23'd0};
    end else begin
      fp_mul = {sr, pk};
    end
  endfunction

  // binary32 add, round to nearest even, subnormals kept
  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0]        big, sml;
    logic               a_inf, b_inf;
    logic [7:0]         eg, es, dd;
    logic [26:0]        bfull, bsh, mask;
    logic               stk;
    logic [27:0]        av, bv, s;
    logic signed [9:0]  e;
    logic [4:0]         lp;
    logic [9:0]         shl;
    logic [23:0]        sig;
    logic               g, st;
    logic [7:0]         ef;
    logic [30:0]        pk;
    a_inf = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
    if (a[30:0] < b[30:0]) begin
      big = b;
      sml = a;
    end else begin
      big = a;
      sml = b;
    end
    eg    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es    = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    dd    = eg - es;
    bfull = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
    if (dd >= 8'd27) begin
      bsh = 27'd0;
      stk = 1'b1;
    end else begin
      bsh  = bfull >> dd;
      mask = (27'd1 << dd) - 27'd1;
      stk  = |(bfull & mask);
    end
    av = {1'b0, big[30:23] != 8'd0, big[22:0], 3'b000};
    bv = {1'b0, bsh[26:1], bsh[0] | stk};
    s  = (big[31] ^ sml[31]) ? (av - bv) : (av + bv);
    e  = $signed({2'b0, eg});
    if (s[27]) begin
      s = {1'b0, s[27:2], s[1] | s[0]};
      e = e + 10'sd1;
    end else begin
      lp = 5'd0;
      for (int i = 0; i < 27; i++) begin
        if (s[i]) lp = i[4:0];
      end
      shl = 10'd26 - {5'd0, lp};
      if ($signed(shl) > e - 10'sd1) shl = e - 10'sd1;
      s = s << shl;
      e = e - $signed(shl);
    end
    sig = s[26:3];
    g   = s[2];
    st  = |s[1:0];
    ef  = s[26] ? e[7:0] : 8'd0;
    pk  = {ef, sig[22:0]} + {30'd0, g & (st | sig[0])};
    if (is_nan(a) || is_nan(b)) begin
      fp_add = CANON_NAN;
    end else if (a_inf && b_inf && (a[31] != b[31])) begin
      fp_add = CANON_NAN;
    end else if (a_inf) begin
      fp_add = a;
    end else if (b_inf) begin
      fp_add = b;
    end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
      fp_add = {a[31] & b[31], 31'd0};
    end else if (a[30:0] == 31'd0) begin
      fp_add = b;
    end else if (b[30:0] == 31'd0) begin
      fp_add = a;
    end else if (s == 28'd0) begin
      fp_add = 32'd0;
    end else if (e >= 10'sd255) begin
      fp_add = {big[31], 8'hff, 23'd0};
    end else begin
      fp_add = {big[31], pk};
    end
  endfunction

endpackage

// ===== design/vector_normalize_fast_inv_sqrt.sv =====
// ----------------------------------------------------------------------------
// vector_normalize_fast_inv_sqrt
// Scales a binary32 2-D vector to about unit length with one Newton step
// on the classic bit-trick inverse square root guess.
// ----------------------------------------------------------------------------
//  channel | signals                            | direction
//  --------+------------------------------------+----------
//  in      | in_valid, in_ready, in_x, in_y     | word in
//  out     | out_valid, out_ready, out_x, out_y | word out
//
// Eight register stages, one binary32 operation each; one word per cycle
// sustained while out_ready is high. The depth is set by the chain of dependent
// operations (x*x, sum, h, h*r, *r, 1.5-, r*k, x*r).
// The whole pipe advances together; it holds while the last stage is full
// and out_ready is low, so a stall drops and repeats nothing.
// Reset (rst, synchronous) clears the stage valid bits only.
// Zero vectors bypass the math; NaN results leave as 0x7fc00000.
// ----------------------------------------------------------------------------
module vector_normalize_fast_inv_sqrt
  import vnfis_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_x,
  input  logic [31:0] in_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_x,
  output logic [31:0] out_y
);

  logic [NUM_STAGES-1:0] vld;
  logic                  adv;

  // input pair and zero flag ride along the pipe
  logic [31:0] x_d [NUM_STAGES-1];
  logic [31:0] y_d [NUM_STAGES-1];
  logic        z_d [NUM_STAGES-1];

  logic [31:0] xx, yy;   // stage 1
  logic [31:0] d2;       // stage 2
  logic [31:0] h3, r3;   // stage 3
  logic [31:0] hr4, r4;  // stage 4
  logic [31:0] hrr5, r5; // stage 5
  logic [31:0] k6, r6;   // stage 6
  logic [31:0] r7;       // stage 7

  assign adv       = !vld[NUM_STAGES-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NUM_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_d[0] <= in_x;
      y_d[0] <= in_y;
      z_d[0] <= (in_x[30:0] == 31'd0) && (in_y[30:0] == 31'd0);
      for (int i = 1; i < NUM_STAGES - 1; i++) begin
        x_d[i] <= x_d[i-1];
        y_d[i] <= y_d[i-1];
        z_d[i] <= z_d[i-1];
      end
      xx   <= fp_mul(in_x, in_x);
      yy   <= fp_mul(in_y, in_y);
      d2   <= fp_add(xx, yy);
      h3   <= fp_mul(FP_HALF, d2);
      r3   <= first_guess(d2);
      hr4  <= fp_mul(h3, r3);
      r4   <= r3;
      hrr5 <= fp_mul(hr4, r4);
      r5   <= r4;
      k6   <= fp_add(FP_THREE_HALVES, {~hrr5[31], hrr5[30:0]});
      r6   <= r5;
      r7   <= fp_mul(r6, k6);
      // zero vector passes through untouched
      out_x <= z_d[NUM_STAGES-2] ? x_d[NUM_STAGES-2]
                                 : canon(fp_mul(x_d[NUM_STAGES-2], r7));
      out_y <= z_d[NUM_STAGES-2] ? y_d[NUM_STAGES-2]
                                 : canon(fp_mul(y_d[NUM_STAGES-2], r7));
    end
  end

endmodule

// ===== design/vnfis_checker.sv =====
// ----------------------------------------------------------------------------
// vnfis_checker
// Port-level checks for the vector normalize pipeline.
// ----------------------------------------------------------------------------
module vnfis_checker
  import vnfis_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [31:0] in_x,
  input logic [31:0] in_y,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_x,
  input logic [31:0] out_y
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y))
    else $error("result word changed while stalled");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("pipe refuses word with empty output");

  a_drain_ready: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("pipe stalls while output drains");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_nan_canon: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_nan(out_x) |-> out_x == CANON_NAN)
    else $error("non-canonical NaN on out_x");

endmodule

bind vector_normalize_fast_inv_sqrt vnfis_checker u_vnfis_checker (.*);
